// ===== rtl/rgbcpf_pkg.sv =====
// Shared types and constants for the RGB888 to client pixel format converter.
package rgbcpf_pkg;

    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned PIX_W      = 32;
    localparam int unsigned CNT_W      = 3;
    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 40;
    localparam int unsigned ADDR_W     = 5;
    localparam int unsigned APB_W      = 32;

    localparam logic [1:0] WMODE_8  = 2'd0;
    localparam logic [1:0] WMODE_16 = 2'd1;
    localparam logic [1:0] WMODE_32 = 2'd2;

    localparam logic [2:0] REG_WIDTH_MODE  = 3'd0;
    localparam logic [2:0] REG_BIG_ENDIAN  = 3'd1;
    localparam logic [2:0] REG_RED_BITS    = 3'd2;
    localparam logic [2:0] REG_GREEN_BITS  = 3'd3;
    localparam logic [2:0] REG_BLUE_BITS   = 3'd4;
    localparam logic [2:0] REG_RED_SHIFT   = 3'd5;
    localparam logic [2:0] REG_GREEN_SHIFT = 3'd6;
    localparam logic [2:0] REG_BLUE_SHIFT  = 3'd7;

    localparam logic [CNT_W-1:0] BYTES_1 = 3'd1;
    localparam logic [CNT_W-1:0] BYTES_2 = 3'd2;
    localparam logic [CNT_W-1:0] BYTES_4 = 3'd4;

    typedef struct packed {
        logic [1:0] width_mode;
        logic       big_endian;
        logic [3:0] red_bits;
        logic [3:0] green_bits;
        logic [3:0] blue_bits;
        logic [4:0] red_shift;
        logic [4:0] green_shift;
        logic [4:0] blue_shift;
    } t_cfg;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              line_end;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_bytes;
        logic [CNT_W-1:0] byte_count;
        logic             line_end_out;
    } t_pix_out;

    // Keeps the top n bits of a channel and places them at the given shift.
    function automatic logic [PIX_W-1:0] place_channel(
        input logic [CHAN_W-1:0] value,
        input logic [3:0]        n,
        input logic [4:0]        shift
    );
        logic [3:0]        nsat;
        logic [CHAN_W-1:0] kept;
        nsat = (n > 4'd8) ? 4'd8 : n;
        kept = value >> (4'd8 - nsat);
        return {{(PIX_W-CHAN_W){1'b0}}, kept} << shift;
    endfunction

endpackage

// ===== rtl/rgbcpf_cfg.sv =====
// Configuration register file with its APB-style access port.
module rgbcpf_cfg
    import rgbcpf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg        r_cfg;
    t_cfg        n_cfg;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_WIDTH_MODE:  n_cfg.width_mode  = pwdata[1:0];
                REG_BIG_ENDIAN:  n_cfg.big_endian  = pwdata[0];
                REG_RED_BITS:    n_cfg.red_bits    = pwdata[3:0];
                REG_GREEN_BITS:  n_cfg.green_bits  = pwdata[3:0];
                REG_BLUE_BITS:   n_cfg.blue_bits   = pwdata[3:0];
                REG_RED_SHIFT:   n_cfg.red_shift   = pwdata[4:0];
                REG_GREEN_SHIFT: n_cfg.green_shift = pwdata[4:0];
                REG_BLUE_SHIFT:  n_cfg.blue_shift  = pwdata[4:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_mode  <= WMODE_32;
            r_cfg.big_endian  <= 1'b0;
            r_cfg.red_bits    <= 4'd8;
            r_cfg.green_bits  <= 4'd8;
            r_cfg.blue_bits   <= 4'd8;
            r_cfg.red_shift   <= 5'd16;
            r_cfg.green_shift <= 5'd8;
            r_cfg.blue_shift  <= 5'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WIDTH_MODE:  prdata = {30'd0, r_cfg.width_mode};
            REG_BIG_ENDIAN:  prdata = {31'd0, r_cfg.big_endian};
            REG_RED_BITS:    prdata = {28'd0, r_cfg.red_bits};
            REG_GREEN_BITS:  prdata = {28'd0, r_cfg.green_bits};
            REG_BLUE_BITS:   prdata = {28'd0, r_cfg.blue_bits};
            REG_RED_SHIFT:   prdata = {27'd0, r_cfg.red_shift};
            REG_GREEN_SHIFT: prdata = {27'd0, r_cfg.green_shift};
            REG_BLUE_SHIFT:  prdata = {27'd0, r_cfg.blue_shift};
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/rgbcpf_conv.sv =====
// Combinational pixel conversion: channel placement, width truncation and byte order.
module rgbcpf_conv
    import rgbcpf_pkg::*;
(
    input  t_cfg     i_cfg,
    input  t_pix_in  i_pix,
    output t_pix_out o_pix
);

    logic [PIX_W-1:0] pixel;
    logic [PIX_W-1:0] result;
    logic [CNT_W-1:0] count;

    assign pixel = place_channel(i_pix.red,   i_cfg.red_bits,   i_cfg.red_shift)
                 | place_channel(i_pix.green, i_cfg.green_bits, i_cfg.green_shift)
                 | place_channel(i_pix.blue,  i_cfg.blue_bits,  i_cfg.blue_shift);

    always_comb begin
        case (i_cfg.width_mode)
            WMODE_8: begin
                count  = BYTES_1;
                result = {24'd0, pixel[7:0]};
            end
            WMODE_16: begin
                count  = BYTES_2;
                result = i_cfg.big_endian ? {16'd0, pixel[7:0], pixel[15:8]}
                                          : {16'd0, pixel[15:0]};
            end
            default: begin
                count  = BYTES_4;
                result = i_cfg.big_endian
                       ? {pixel[7:0], pixel[15:8], pixel[23:16], pixel[31:24]}
                       : pixel;
            end
        endcase
    end

    assign o_pix.pixel_bytes  = result;
    assign o_pix.byte_count   = count;
    assign o_pix.line_end_out = i_pix.line_end;

endmodule

// ===== rtl/rgb888_to_client_pixel_format_unit.sv =====
// Top level of the RGB888 to client pixel format converter.
//
//   Channel    Direction  Payload
//   s stream   in         tdata = red[7:0], green[15:8], blue[23:16]; tlast = line end
//   m stream   out        tdata = pixel_bytes[31:0], byte_count[34:32], zero[39:35];
//                         tlast = line end
//   APB        in/out     eight configuration registers at byte addresses 0 to 28
//
// A word passes from acceptance into the input register and then into the result register,
// with the conversion logic between them.
// One word is accepted every cycle while the output side keeps taking words.
// A stall on the output backs up both registers, then input ready drops.
// Synchronous reset empties both registers and loads the default 32-bit format.
module rgb888_to_client_pixel_format_unit
    import rgbcpf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // red, green, blue from bit 0 up
    input  logic                  i_s_tlast,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // pixel_bytes, byte_count, zero padding
    output logic                  o_m_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_W-1:0]      pwdata,
    output logic [APB_W-1:0]      prdata,
    output logic                  pready
);

    t_cfg     cfg;
    t_pix_in  r_in;
    logic     r_in_valid;
    t_pix_out conv_out;
    t_pix_out r_out;
    logic     r_out_valid;
    logic     out_free;
    logic     in_adv;

    rgbcpf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rgbcpf_conv u_conv (
        .i_cfg (cfg),
        .i_pix (r_in),
        .o_pix (conv_out)
    );

    assign out_free   = !r_out_valid || i_m_tready;
    assign in_adv     = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.red      <= i_s_tdata[7:0];
            r_in.green    <= i_s_tdata[15:8];
            r_in.blue     <= i_s_tdata[23:16];
            r_in.line_end <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv) begin
            r_out <= conv_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out.byte_count, r_out.pixel_bytes};
    assign o_m_tlast  = r_out.line_end_out;

`ifndef NO_ASSERTIONS
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_s_tready)
        else $error("input not ready while input register is empty");

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_tready) |-> !o_s_tready)
        else $error("input ready while both registers hold stalled words");

    a_count_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_out.byte_count == BYTES_1 || r_out.byte_count == BYTES_2 ||
                        r_out.byte_count == BYTES_4))
        else $error("illegal byte count on output");

    a_unused_bytes_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_out.byte_count == BYTES_1) |-> (r_out.pixel_bytes[31:8] == '0))
        else $error("bytes beyond the byte count are not zero");

    a_advance_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_adv |=> r_out_valid)
        else $error("converted word lost between registers");
`endif

endmodule
